// File: design/pge_pkg.sv
package pge_pkg;

	// channel shift distance and derived sizes
	localparam int SHIFT_DISTANCE = 3;
	localparam int WIN_DEPTH      = 2 * SHIFT_DISTANCE + 1;
	localparam int MAX_RESULTS    = SHIFT_DISTANCE + 1;
	localparam int FILL_W         = $clog2(WIN_DEPTH + 1);
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W          = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	// effect codes
	localparam logic [2:0] MODE_PASS      = 3'd0;
	localparam logic [2:0] MODE_INVERT    = 3'd1;
	localparam logic [2:0] MODE_SHIFT     = 3'd2;
	localparam logic [2:0] MODE_POSTERIZE = 3'd3;
	localparam logic [2:0] MODE_CONTRAST  = 3'd4;

	// register map
	localparam logic REG_EFFECT_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
		logic       line_last;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       line_end;
		logic       run_last;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// contrast: clamp(floor((3v - 128) / 2), 0, 255)
	function automatic logic [7:0] contrast(input logic [7:0] v);
		logic [9:0] t;
		logic [9:0] d;
		begin
			t = {1'b0, v, 1'b0} + {2'b00, v};
			d = t - 10'd128;
			if (t < 10'd128) begin
				contrast = 8'd0;
			end else if (d[9:1] > 9'd255) begin
				contrast = 8'd255;
			end else begin
				contrast = d[8:1];
			end
		end
	endfunction

	// per-channel point effects; unused codes pass
	function automatic logic [7:0] point_fx(input logic [2:0] mode, input logic [7:0] v);
		begin
			case (mode)
				MODE_INVERT:    point_fx = 8'd255 - v;
				MODE_POSTERIZE: point_fx = v & 8'hC0;
				MODE_CONTRAST:  point_fx = contrast(v);
				default:        point_fx = v;
			endcase
		end
	endfunction

endpackage

// File: design/pge_core.sv
module pge_core
	import pge_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [2:0]                       mode,
	input  pixel_in_t                        pix,
	output pixel_out_t [MAX_RESULTS-1:0]     res,
	output logic [CNT_W-1:0]                 res_cnt
);

	rgba_t                     win_q [WIN_DEPTH];
	logic [FILL_W-1:0]         fill_q;

	rgba_t                     w     [WIN_DEPTH];
	rgba_t                     use_w [WIN_DEPTH];
	rgba_t                     sh    [MAX_RESULTS];
	pixel_out_t                cand  [MAX_RESULTS];
	logic [MAX_RESULTS-1:0]    cand_ok;
	logic [FILL_W-1:0]         nfill;
	logic [FILL_W-1:0]         use_f;
	logic                      shift_mode;
	logic [CNT_W-1:0]          n;

	// window after taking in the new pixel, and the shifted view of it
	always_comb begin
		shift_mode = (mode == MODE_SHIFT);
		w[0] = '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in,
			alpha: pix.alpha_in};
		for (int i = 1; i < WIN_DEPTH; i++) begin
			w[i] = win_q[i-1];
		end
		nfill = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + 1'b1;
		use_f = shift_mode ? nfill : fill_q;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			use_w[i] = shift_mode ? w[i] : win_q[i];
		end
		// red from the right neighbor, blue from the left one, own value at edges
		for (int k = 0; k < MAX_RESULTS; k++) begin
			sh[k] = use_w[k];
			if (FILL_W'(k + SHIFT_DISTANCE) < use_f) begin
				sh[k].blue = use_w[k + SHIFT_DISTANCE].blue;
			end
		end
		sh[SHIFT_DISTANCE].red = use_w[0].red;
	end

	// candidate words in output order
	always_comb begin
		for (int j = 0; j < MAX_RESULTS; j++) begin
			cand[j] = '0;
			cand_ok[j] = 1'b0;
			if (shift_mode) begin
				cand[j].red_out   = sh[SHIFT_DISTANCE-j].red;
				cand[j].green_out = sh[SHIFT_DISTANCE-j].green;
				cand[j].blue_out  = sh[SHIFT_DISTANCE-j].blue;
				cand[j].alpha_out = sh[SHIFT_DISTANCE-j].alpha;
				if (j == 0) begin
					cand_ok[j] = (nfill >= FILL_W'(SHIFT_DISTANCE + 1));
				end else begin
					cand_ok[j] = pix.line_last &&
						(FILL_W'(SHIFT_DISTANCE - j) < nfill);
				end
			end else if (j < SHIFT_DISTANCE) begin
				// pending pixels left over from shift mode
				cand[j].red_out   = sh[SHIFT_DISTANCE-1-j].red;
				cand[j].green_out = sh[SHIFT_DISTANCE-1-j].green;
				cand[j].blue_out  = sh[SHIFT_DISTANCE-1-j].blue;
				cand[j].alpha_out = sh[SHIFT_DISTANCE-1-j].alpha;
				cand_ok[j] = (FILL_W'(SHIFT_DISTANCE - 1 - j) < fill_q);
			end else begin
				cand[j].red_out   = point_fx(mode, pix.red_in);
				cand[j].green_out = point_fx(mode, pix.green_in);
				cand[j].blue_out  = point_fx(mode, pix.blue_in);
				cand[j].alpha_out = pix.alpha_in;
				cand_ok[j] = 1'b1;
			end
			if (j == SHIFT_DISTANCE) begin
				cand[j].line_end = pix.line_last;
			end
		end
	end

	// pack the valid words to the front and mark the last
	always_comb begin
		res = '0;
		n = '0;
		for (int j = 0; j < MAX_RESULTS; j++) begin
			if (cand_ok[j]) begin
				res[n[IDX_W-1:0]] = cand[j];
				n = n + 1'b1;
			end
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i].run_last = (CNT_W'(i + 1) == n);
		end
		res_cnt = n;
	end

	// line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			if (shift_mode && !pix.line_last) begin
				fill_q <= nfill;
			end else begin
				fill_q <= '0;
			end
		end
	end

	// pixel window, entries past the line count are never read
	always_ff @(posedge clk) begin
		if (step && shift_mode) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= w[i];
			end
		end
	end

endmodule

// File: design/pixel_glitch_effect_stream_top.sv
// Path: a word accepted into the input stage (pix_s1) is processed once the burst
// register is free, and its first result shows from burst_q; shift mode holds each
// pixel back by three pixels and flushes the rest at line end.
// Throughput: one pixel per cycle while each pixel yields one result and res_ready
// is high; k results hold the output until taken; the one-word input stage absorbs it.
// Reset: arst_n clears the mode register, line count and word counts; no clearing pass.
module pixel_glitch_effect_stream_top
	import pge_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  pixel_in_t   pix_data,
	output logic        res_valid,
	input  logic        res_ready,
	output pixel_out_t  res_data
);

	logic [2:0]                    effect_mode_q;
	logic                          valid_s1;
	pixel_in_t                     pix_s1;
	pixel_out_t                    burst_q [MAX_RESULTS];
	logic [CNT_W-1:0]              burst_cnt_q;
	pixel_out_t [MAX_RESULTS-1:0]  gen;
	logic [CNT_W-1:0]              gen_cnt;
	logic                          step;
	logic                          take;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EFFECT_MODE) ? {29'd0, effect_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= MODE_PASS;
		end else if (psel && penable && pwrite && paddr[2] == REG_EFFECT_MODE) begin
			effect_mode_q <= pwdata[2:0];
		end
	end

	// handshake control
	assign take      = res_valid && res_ready;
	assign step      = valid_s1 && (burst_cnt_q == '0 ||
		(burst_cnt_q == CNT_W'(1) && res_ready));
	assign pix_ready = !valid_s1 || step;
	assign res_valid = (burst_cnt_q != '0);
	assign res_data  = burst_q[0];

	pge_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.mode    (effect_mode_q),
		.pix     (pix_s1),
		.res     (gen),
		.res_cnt (gen_cnt)
	);

	// input stage and burst count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			burst_cnt_q <= '0;
		end else begin
			if (pix_valid && pix_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				burst_cnt_q <= gen_cnt;
			end else if (take) begin
				burst_cnt_q <= burst_cnt_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= pix_data;
		end
		if (step) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				burst_q[i] <= gen[i];
			end
		end else if (take) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				burst_q[i] <= burst_q[i+1];
			end
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("burst count out of range");

	a_no_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(burst_cnt_q > CNT_W'(1)) |-> !step)
		else $error("new word processed while burst still draining");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> valid_s1)
		else $error("input stalled with empty input stage");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && burst_cnt_q == CNT_W'(1) && !step) |=> !res_valid)
		else $error("output still valid after last word taken");

	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && burst_cnt_q == CNT_W'(1)) |-> res_data.run_last)
		else $error("final word of a run not marked");

endmodule
